// ----- sv/itr_pkg.sv -----
// Shared types, constants and symbol lookup for the radix text converter.
// No dependencies; every other file except itr_ram imports this package.
package itr_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_RADIX      = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  localparam logic [7:0] SIGN_MINUS = 8'h2D;
  localparam logic [7:0] SIGN_PLUS  = 8'h2B;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX_SIZE   = 2'd0,
    REG_SYMBOLS_LOW  = 2'd1,
    REG_SYMBOLS_HIGH = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SIGN,
    S_RD,
    S_OUT,
    S_ERR
  } state_t;

  // Result of the symbol set check: done pulses once, ok qualifies it.
  typedef struct packed {
    logic done;
    logic ok;
  } chk_res_t;

  function automatic logic [7:0] sym_of(input logic [63:0] lo, input logic [63:0] hi,
                                        input logic [3:0] d);
    logic [63:0] w;
    w = d[3] ? hi : lo;
    return w[{d[2:0], 3'b000} +: 8];
  endfunction

endpackage

// ----- sv/itr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module itr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/itr_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, divisor up to 16.
// Depends on itr_pkg for the default width.
module itr_div #(
  parameter int W = itr_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [4:0]   radix,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [3:0]   rem
);
  import itr_pkg::*;

  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [3:0]    rem_r, rem_nxt;
  logic [4:0]    trial;
  logic [4:0]    diff;
  logic          fits;

  // Bring down the next dividend bit and subtract the radix when it fits.
  assign trial = {rem_r, q_r[W-1]};
  assign fits  = (trial >= radix);
  assign diff  = trial - radix;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt   = {q_r[W-2:0], fits};
      rem_nxt = fits ? diff[3:0] : trial[3:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

// ----- sv/itr_check.sv -----
// Symbol set checker: walks the symbols in use one per cycle, rejecting a
// bad radix, a sign or zero byte, or a duplicate. Depends on itr_pkg.
module itr_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [4:0]         radix_size,
  input  logic [63:0]        sym_lo,
  input  logic [63:0]        sym_hi,
  output itr_pkg::chk_res_t  res
);
  import itr_pkg::*;

  logic       run_r, run_nxt;
  logic [3:0] idx_r, idx_nxt;
  chk_res_t   res_r, res_nxt;
  logic [7:0] cur_sym;
  logic       bad_sym;
  logic       dup;
  logic       range_bad;
  logic       last_idx;

  assign cur_sym   = sym_of(sym_lo, sym_hi, idx_r);
  assign bad_sym   = (cur_sym == 8'h00) || (cur_sym == SIGN_MINUS) || (cur_sym == SIGN_PLUS);
  assign range_bad = (radix_size < 5'd2) || (radix_size > 5'(MAX_RADIX));
  assign last_idx  = (({1'b0, idx_r} + 5'd1) == radix_size);

  // Compare the current symbol against every later symbol in use.
  always_comb begin
    dup = 1'b0;
    for (int b = 0; b < 16; b++) begin
      if ((b > int'(idx_r)) && (b < int'(radix_size)) &&
          (sym_of(sym_lo, sym_hi, 4'(b)) == cur_sym)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    run_nxt = run_r;
    idx_nxt = idx_r;
    res_nxt = '0;
    if (start) begin
      if (range_bad) begin
        run_nxt = 1'b0;
        res_nxt = '{done: 1'b1, ok: 1'b0};
      end else begin
        run_nxt = 1'b1;
        idx_nxt = '0;
      end
    end else if (run_r) begin
      if (bad_sym || dup) begin
        run_nxt = 1'b0;
        res_nxt = '{done: 1'b1, ok: 1'b0};
      end else if (last_idx) begin
        run_nxt = 1'b0;
        res_nxt = '{done: 1'b1, ok: 1'b1};
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      idx_r <= '0;
      res_r <= '0;
    end else begin
      run_r <= run_nxt;
      idx_r <= idx_nxt;
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- sv/integer_to_radix_text.sv -----
// Converts a signed integer (low VALUE_BITS bits of in_value) to text in the
// radix set by radix_size, one character per output request, most significant
// first, with a leading '-' when negative and last_char on the final one. A
// rejected symbol set gives a single request with radix_invalid set. One number
// is handled at a time. The bit-serial divider produces each digit, least
// significant first, into the digit RAM, which is read back from the top; its
// registered read puts a read state before each digit character.
// Depends on itr_pkg, itr_check, itr_div and itr_ram.
module integer_to_radix_text #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_char_out,
  output logic                               out_last_char,
  output logic                               out_radix_invalid,
  input  logic                               cfg_wr_en,
  input  logic [itr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [itr_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import itr_pkg::*;

  localparam int AW = $clog2(VALUE_BITS);
  localparam int CW = $clog2(VALUE_BITS + 1);

  state_t state_r, state_nxt;

  logic [4:0]            radix_size_r;
  logic [63:0]           sym_lo_r;
  logic [63:0]           sym_hi_r;

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_err_r, out_err_nxt;

  logic [VALUE_BITS-1:0] v_bits;
  logic [VALUE_BITS-1:0] v_mag;
  logic                  accept;
  logic                  slot_free;
  logic                  out_load;
  logic [7:0]            ld_char;
  logic                  ld_last;
  logic                  ld_err;

  chk_res_t              chk_res;
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quot;
  logic [3:0]            div_rem;
  logic                  ram_we;
  logic [3:0]            ram_rd_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_size_r <= '0;
      sym_lo_r     <= '0;
      sym_hi_r     <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RADIX_SIZE:   radix_size_r <= cfg_data[4:0];
        REG_SYMBOLS_LOW:  sym_lo_r     <= cfg_data;
        REG_SYMBOLS_HIGH: sym_hi_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign v_bits    = in_value[VALUE_BITS-1:0];
  assign v_mag     = v_bits[VALUE_BITS-1] ? (~v_bits + 1'b1) : v_bits;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign div_dividend = (state_r == S_CHECK) ? mag_r : div_quot;

  itr_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (accept),
    .radix_size (radix_size_r),
    .sym_lo     (sym_lo_r),
    .sym_hi     (sym_hi_r),
    .res        (chk_res)
  );

  itr_div #(
    .W (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (radix_size_r),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  itr_ram #(
    .WIDTH (4),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (div_rem),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (chk_res.done) state_nxt = chk_res.ok ? S_DIV : S_ERR;
      end
      S_DIV: begin
        if (div_done && (div_quot == '0)) state_nxt = neg_r ? S_SIGN : S_RD;
      end
      S_SIGN: begin
        if (slot_free) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) state_nxt = (rd_idx_r == '0) ? S_IDLE : S_RD;
      end
      S_ERR: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control.
  always_comb begin
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    ld_char    = 8'h00;
    ld_last    = 1'b0;
    ld_err     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt = v_bits[VALUE_BITS-1];
          mag_nxt = v_mag;
        end
      end
      S_CHECK: begin
        if (chk_res.done && chk_res.ok) begin
          div_start = 1'b1;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ram_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          // Keep dividing until the quotient runs out, then read back from the top.
          if (div_quot != '0) begin
            div_start = 1'b1;
          end else begin
            rd_idx_nxt = cnt_r[AW-1:0];
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_char  = SIGN_MINUS;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_char  = sym_of(sym_lo_r, sym_hi_r, ram_rd_data);
          ld_last  = (rd_idx_r == '0);
          if (rd_idx_r != '0) rd_idx_nxt = rd_idx_r - 1'b1;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_last  = 1'b1;
          ld_err   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold the request until taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = ld_char;
      out_last_nxt  = ld_last;
      out_err_nxt   = ld_err;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
      cnt_r       <= cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_char_out      = out_char_r;
  assign out_last_char     = out_last_r;
  assign out_radix_invalid = out_err_r;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output request overwritten before it was taken");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_radix_invalid) |-> (out_char_out == 8'h00 && out_last_char))
    else $error("error request carries a character or lacks last_char");

  a_div_start_src: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == S_CHECK || state_r == S_DIV))
    else $error("divider started outside conversion");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> (rd_idx_r < cnt_r))
    else $error("digit read beyond the digits produced");
`endif

endmodule

// ----- verif/itr_text_checker.sv -----
// Checker for integer_to_radix_text: tracks config writes, predicts the text of
// each accepted request and compares every output character against it.
// Depends on itr_pkg for the register indexes and sign characters.
`timescale 1ns / 1ps

module itr_text_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [31:0]                    in_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [7:0]                     out_char_out,
  input  logic                           out_last_char,
  input  logic                           out_radix_invalid,
  input  logic                           cfg_wr_en,
  input  logic [itr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [itr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             chars_pending
);
  import itr_pkg::*;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
    logic       radix_invalid;
  } text_char_t;

  text_char_t   expected_text[$];
  logic [4:0]   radix_q;
  logic [127:0] symbol_bytes_q;  // digit d lives in byte d

  function automatic logic [7:0] digit_symbol(input logic [3:0] d);
    return symbol_bytes_q[8*d +: 8];
  endfunction

  function automatic logic symbol_set_ok();
    logic [7:0] s;
    if (radix_q < 2 || radix_q > MAX_RADIX) return 1'b0;
    for (int a = 0; a < radix_q; a++) begin
      s = digit_symbol(4'(a));
      if (s == 8'h00 || s == SIGN_PLUS || s == SIGN_MINUS) return 1'b0;
      for (int b = a + 1; b < radix_q; b++)
        if (digit_symbol(4'(b)) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_text(input logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [3:0]  digits[32];
    int          n;
    if (!symbol_set_ok()) begin
      expected_text.push_back(text_char_t'({8'h00, 1'b1, 1'b1}));
      return;
    end
    radix = 32'(radix_q);
    // most negative value wraps to 2^31, which is exactly its magnitude
    mag = v[31] ? -v : v;
    n = 0;
    do begin
      digits[n] = 4'(mag % radix);
      n++;
      mag = mag / radix;
    end while (mag != 0);
    if (v[31]) expected_text.push_back(text_char_t'({SIGN_MINUS, 1'b0, 1'b0}));
    for (int i = n - 1; i >= 0; i--)
      expected_text.push_back(text_char_t'({digit_symbol(digits[i]), i == 0, 1'b0}));
  endfunction

  function automatic void note_mismatch(input string what, input text_char_t want,
                                        input text_char_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %02h last %0b invalid %0b, got %02h last %0b invalid %0b",
               $time, what, want.char_out, want.last_char, want.radix_invalid,
               got.char_out, got.last_char, got.radix_invalid);
  endfunction

  initial mismatch_count = 0;

  always @(posedge clk) begin
    text_char_t got;
    text_char_t want;
    if (!rst_n) begin
      radix_q = '0;
      symbol_bytes_q = '0;
      expected_text.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RADIX_SIZE:   radix_q = cfg_data[4:0];
          REG_SYMBOLS_LOW:  symbol_bytes_q[63:0] = cfg_data;
          REG_SYMBOLS_HIGH: symbol_bytes_q[127:64] = cfg_data;
          default: ;  // no register behind this index
        endcase
      end
      if (in_valid && in_ready) predict_text(in_value);
      if (out_valid && out_ready) begin
        got = text_char_t'({out_char_out, out_last_char, out_radix_invalid});
        if (expected_text.size() == 0) begin
          note_mismatch("character with no request pending", '0, got);
        end else begin
          want = expected_text.pop_front();
          if (got.char_out !== want.char_out || got.last_char !== want.last_char ||
              got.radix_invalid !== want.radix_invalid)
            note_mismatch("character mismatch", want, got);
        end
      end
    end
    chars_pending <= expected_text.size();
  end

endmodule

// ----- verif/integer_to_radix_text_tb.sv -----
// Top of the integer_to_radix_text testbench: clock, reset, config writes,
// request stimulus with bursts and gaps, output back-pressure and the verdict.
// Depends on itr_pkg, the block and itr_text_checker.
`timescale 1ns / 1ps

module integer_to_radix_text_tb;
  import itr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;  // unmapped index
  localparam int RANDOM_ITEMS     = 225;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = 40;
  localparam int LIMIT_NS         = 8_000_000;

  localparam logic [127:0] SYMS_HEX = {64'h6665646362613938, 64'h3736353433323130};
  // digits 0-9, unused bytes hold '+', '-', zero and a repeat
  localparam logic [127:0] SYMS_DEC = {64'h2B00382D002B3938, 64'h3736353433323130};
  localparam logic [127:0] SYMS_BIN = {64'h0, 64'h30312B2D00003130};
  localparam logic [127:0] SYMS_HIBIT = {64'h0, 64'h00000000000180FF};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic signed [31:0]    in_value;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_char_out;
  logic                  out_last_char;
  logic                  out_radix_invalid;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  long_hold_armed;
  int                    mismatch_count;
  int                    chars_pending;
  int                    burst_left;

  integer_to_radix_text u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char_out      (out_char_out),
    .out_last_char     (out_last_char),
    .out_radix_invalid (out_radix_invalid),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  itr_text_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char_out      (out_char_out),
    .out_last_char     (out_last_char),
    .out_radix_invalid (out_radix_invalid),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .chars_pending     (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("timeout: conversion did not drain");
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: switch between stall patterns, with one long hold-off.
  initial begin : receiver
    int mode;
    int mode_left;
    bit held;
    mode = 0;
    mode_left = 0;
    held = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_armed && !held && out_valid) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // Offer one request and hold it until accepted; after a burst, usually open a gap.
  task automatic send_value(input logic [31:0] v);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  endtask

  // Drop the request line and wait until every predicted character is out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  task automatic cfg_drive(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_set(input logic [63:0] radix_word, input logic [127:0] syms);
    settle();
    cfg_drive(REG_RADIX_SIZE, radix_word);
    cfg_drive(REG_SYMBOLS_LOW, syms[63:0]);
    cfg_drive(REG_SYMBOLS_HIGH, syms[127:64]);
    cfg_wr_en <= 1'b0;
  endtask

  // Sixteen distinct symbols, none of them zero, '+' or '-'.
  function automatic logic [127:0] make_symbols();
    logic [127:0] syms;
    logic [7:0]   b;
    bit           clash;
    syms = '0;
    for (int k = 0; k < 16; k++) begin
      do begin
        b = 8'($urandom_range(1, 255));
        clash = (b == SIGN_PLUS || b == SIGN_MINUS);
        for (int j = 0; j < k; j++)
          if (syms[8*j +: 8] == b) clash = 1;
      end while (clash);
      syms[8*k +: 8] = b;
    end
    return syms;
  endfunction

  task automatic random_config(output int radix);
    logic [127:0] syms;
    logic [63:0]  junk;
    logic [63:0]  radix_word;
    int           a;
    int           b;
    syms = make_symbols();
    case ($urandom_range(0, 3))
      0: radix = 2;
      1: radix = 16;
      default: radix = $urandom_range(2, 16);
    endcase
    a = $urandom_range(0, radix - 1);
    b = (a + $urandom_range(1, radix - 1)) % radix;
    case ($urandom_range(0, 11))
      0: radix = $urandom_range(0, 1);
      1: radix = $urandom_range(17, 31);
      2: syms[8*a +: 8] = SIGN_PLUS;
      3: syms[8*a +: 8] = SIGN_MINUS;
      4: syms[8*a +: 8] = 8'h00;
      5: syms[8*b +: 8] = syms[8*a +: 8];
      default: begin
        // sometimes poison a byte past the radix; it must be ignored
        if (radix < 16 && $urandom_range(0, 1) == 1)
          syms[8*$urandom_range(radix, 15) +: 8] = ($urandom_range(0, 1) == 1) ? SIGN_MINUS
                                                                                : 8'h00;
      end
    endcase
    junk = {$urandom(), $urandom()};
    radix_word = {($urandom_range(0, 1) == 1) ? junk[63:5] : 59'd0, 5'(radix)};
    program_set(radix_word, syms);
  endtask

  function automatic logic [31:0] pick_value(input int radix);
    int          r;
    logic [31:0] p;
    r = (radix < 2) ? 2 : ((radix > 16) ? 16 : radix);
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return $urandom_range(0, 2 * r * r);
      3: return -32'($urandom_range(0, 1000));
      4: begin
        p = 1;
        repeat ($urandom_range(0, 7)) p = p * r;
        if ($urandom_range(0, 1) == 1) p = p - 1;
        return ($urandom_range(0, 1) == 1) ? -p : p;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    int radix;
    int random_sent;
    int phase_items;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_value        <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= REG_RADIX_SIZE;
    cfg_data        <= '0;
    long_hold_armed <= 1'b0;
    burst_left = 1;
    random_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config has radix zero: rejected
    send_value(32'd5);
    program_set(64'd1, SYMS_HEX);
    send_value(32'd7);
    program_set(64'd17, SYMS_HEX);
    send_value(-32'd7);
    program_set(64'hFFFF_FFFF_FFFF_FFFF, SYMS_HEX);
    send_value(32'd0);

    // decimal, junk above the radix field
    program_set(64'hA5A5_A5A5_A5A5_A5AA, SYMS_DEC);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd42);
    send_value(-32'd1000);

    program_set(64'd2, SYMS_BIN);
    send_value(32'd0);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);

    program_set(64'd16, SYMS_HEX);
    send_value(32'hDEAD_BEEF);
    send_value(32'h7FFF_FFFF);
    send_value(32'd16);

    program_set(64'd16, {SYMS_HEX[127:48], SIGN_PLUS, SYMS_HEX[39:0]});
    send_value(32'd9);
    program_set(64'd16, {SIGN_MINUS, SYMS_HEX[119:0]});
    send_value(32'd9);
    program_set(64'd16, {SYMS_HEX[127:8], 8'h00});
    send_value(32'd9);
    program_set(64'd16, {SYMS_HEX[127:80], SYMS_HEX[31:24], SYMS_HEX[71:0]});
    send_value(32'd9);

    // write to the unmapped index must leave the hex set intact
    program_set(64'd16, SYMS_HEX);
    cfg_drive(REG_NONE, '0);
    cfg_wr_en <= 1'b0;
    send_value(-32'd255);

    program_set(64'd3, SYMS_HIBIT);
    send_value(-32'd7);
    send_value(32'h7FFF_FFFF);

    long_hold_armed <= 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      random_config(radix);
      phase_items = $urandom_range(10, 30);
      repeat (phase_items) begin
        send_value(pick_value(radix));
        random_sent++;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- integer_to_radix_text.f -----
sv/itr_pkg.sv
sv/itr_ram.sv
sv/itr_div.sv
sv/itr_check.sv
sv/integer_to_radix_text.sv
verif/itr_text_checker.sv
verif/integer_to_radix_text_tb.sv
